// ===== rtl/escaped_frame_receiver_unit_assert.svh =====
// assertion macros used by the receiver control module
`ifndef ESCAPED_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define ESCAPED_FRAME_RECEIVER_UNIT_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define EFR_ASSERT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("efr assertion failed");
// next-cycle implication
`define EFR_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("efr assertion failed");
`else
`define EFR_ASSERT(label, clk, rst_n, cond, prop)
`define EFR_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

// ===== rtl/efr_pkg.sv =====
package efr_pkg;

    localparam int FRAME_CAPACITY = 40;

    // frame positions run 0 .. FRAME_CAPACITY + 1
    localparam int POS_W     = $clog2(FRAME_CAPACITY + 2);
    // payload lands at positions 3 .. FRAME_CAPACITY
    localparam int BUF_DEPTH = FRAME_CAPACITY - 2;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);

    localparam int BYTE_INDEX_W = 6;

    localparam logic [7:0] START_BYTE  = 8'h7E;
    localparam logic [7:0] ESCAPE_BYTE = 8'h7D;
    localparam logic [7:0] ESCAPE_XOR  = 8'h20;
    localparam logic [7:0] SUM_GOOD    = 8'hFF;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_UNEXP_START = 2'd1,
        STATUS_ZERO_LEN   = 2'd2,
        STATUS_BAD_SUM    = 2'd3
    } t_status;

    typedef struct packed {
        logic accept;
        logic rd_en;
        logic load;
    } t_dp_cmd;

    typedef struct packed {
        logic drain_start;
        logic last_idx;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== rtl/efr_datapath.sv =====
module efr_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  efr_pkg::t_dp_cmd      i_cmd,
    output efr_pkg::t_dp_sts      o_sts,
    input  logic [7:0]            i_rx_byte,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic [1:0]            o_status,
    output logic [7:0]            o_frame_command,
    output logic [7:0]            o_payload_byte,
    output logic                  o_byte_valid,
    output logic [efr_pkg::BYTE_INDEX_W-1:0] o_byte_index,
    output logic                  o_last
);

    logic [efr_pkg::POS_W-1:0]  r_pos, n_pos;
    logic [7:0]                 r_len, n_len;
    logic [7:0]                 r_cmd, n_cmd;
    logic [7:0]                 r_sum, n_sum;
    logic                       r_esc, n_esc;
    logic                       r_err, n_err;
    logic [efr_pkg::ADDR_W-1:0] r_k;

    logic [7:0] r_buf [efr_pkg::BUF_DEPTH];
    logic [7:0] r_rd_data;

    logic                 r_out_valid;
    logic [1:0]           r_out_status;
    logic [7:0]           r_out_cmd;
    logic [7:0]           r_out_data;
    logic                 r_out_bvalid;
    logic [efr_pkg::ADDR_W-1:0] r_out_index;
    logic                 r_out_last;

    logic [7:0]                d;
    logic [7:0]                sum_add;
    logic                      at_end;
    logic [efr_pkg::POS_W-1:0] wr_off;
    logic                      wr_en;
    logic                      emit;
    efr_pkg::t_status          emit_code;
    logic                      drain;
    logic                      last_idx;
    logic                      out_free;

    assign d       = r_esc ? (i_rx_byte ^ efr_pkg::ESCAPE_XOR) : i_rx_byte;
    assign sum_add = r_sum + d;
    assign at_end  = (9'(r_pos) == ({1'b0, r_len} + 9'd2));
    assign wr_off  = r_pos - efr_pkg::POS_W'(3);
    assign last_idx = (8'(r_k) == (r_len - 8'd2));
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_pos     = r_pos;
        n_len     = r_len;
        n_cmd     = r_cmd;
        n_sum     = r_sum;
        n_esc     = r_esc;
        n_err     = r_err;
        wr_en     = 1'b0;
        emit      = 1'b0;
        emit_code = efr_pkg::STATUS_OK;
        drain     = 1'b0;
        if (i_cmd.accept) begin
            if (r_err || r_pos == '0) begin
                // waiting for a start byte, everything else dropped
                if (i_rx_byte == efr_pkg::START_BYTE) begin
                    n_err = 1'b0;
                    n_pos = efr_pkg::POS_W'(1);
                    n_sum = '0;
                    n_esc = 1'b0;
                end
            end else if (i_rx_byte == efr_pkg::START_BYTE) begin
                n_err     = 1'b1;
                n_esc     = 1'b0;
                emit      = 1'b1;
                emit_code = efr_pkg::STATUS_UNEXP_START;
            end else if (i_rx_byte == efr_pkg::ESCAPE_BYTE) begin
                n_esc = 1'b1;
            end else begin
                n_esc = 1'b0;
                if (r_pos > efr_pkg::POS_W'(1)) begin
                    n_sum = sum_add;
                end
                priority if (r_pos == efr_pkg::POS_W'(1)) begin
                    if (d == 8'd0) begin
                        n_pos     = '0;
                        n_err     = 1'b1;
                        emit      = 1'b1;
                        emit_code = efr_pkg::STATUS_ZERO_LEN;
                    end else begin
                        n_len = d;
                        n_pos = efr_pkg::POS_W'(2);
                    end
                end else if (r_pos == efr_pkg::POS_W'(2)) begin
                    n_cmd = d;
                    n_pos = efr_pkg::POS_W'(3);
                end else if (r_pos > efr_pkg::POS_W'(efr_pkg::FRAME_CAPACITY)) begin
                    // past capacity: dropped until a start byte
                end else if (at_end) begin
                    n_pos = '0;
                    n_sum = '0;
                    if (sum_add != efr_pkg::SUM_GOOD) begin
                        n_err     = 1'b1;
                        emit      = 1'b1;
                        emit_code = efr_pkg::STATUS_BAD_SUM;
                    end else if (r_len == 8'd1) begin
                        emit      = 1'b1;
                        emit_code = efr_pkg::STATUS_OK;
                    end else begin
                        drain = 1'b1;
                    end
                end else begin
                    wr_en = 1'b1;
                    n_pos = r_pos + efr_pkg::POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_sum <= '0;
            r_esc <= 1'b0;
            r_err <= 1'b0;
        end else begin
            r_pos <= n_pos;
            r_sum <= n_sum;
            r_esc <= n_esc;
            r_err <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len <= n_len;
        r_cmd <= n_cmd;
        if (i_cmd.accept && drain) begin
            r_k <= '0;
        end else if (i_cmd.load) begin
            r_k <= r_k + efr_pkg::ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_buf[wr_off[efr_pkg::ADDR_W-1:0]] <= d;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_buf[r_k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit || i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_status <= emit_code;
            r_out_cmd    <= (emit_code == efr_pkg::STATUS_OK) ? r_cmd : 8'd0;
            r_out_data   <= 8'd0;
            r_out_bvalid <= 1'b0;
            r_out_index  <= '0;
            r_out_last   <= 1'b1;
        end else if (i_cmd.load) begin
            r_out_status <= efr_pkg::STATUS_OK;
            r_out_cmd    <= r_cmd;
            r_out_data   <= r_rd_data;
            r_out_bvalid <= 1'b1;
            r_out_index  <= r_k;
            r_out_last   <= last_idx;
        end
    end

    assign o_sts.drain_start = drain;
    assign o_sts.last_idx    = last_idx;
    assign o_sts.out_free    = out_free;

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_frame_command = r_out_cmd;
    assign o_payload_byte  = r_out_data;
    assign o_byte_valid    = r_out_bvalid;
    assign o_byte_index    = efr_pkg::BYTE_INDEX_W'(r_out_index);
    assign o_last          = r_out_last;

endmodule

// ===== rtl/efr_ctrl.sv =====
`include "escaped_frame_receiver_unit_assert.svh"

module efr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  efr_pkg::t_dp_sts i_sts,
    output efr_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_RUN  = 3'b001,
        S_READ = 3'b010,
        S_LOAD = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   accept;
    logic   rd_en;
    logic   load;

    always_comb begin
        n_state    = r_state;
        accept     = 1'b0;
        rd_en      = 1'b0;
        load       = 1'b0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_RUN: begin
                o_in_stall = !i_sts.out_free;
                accept     = i_in_valid && i_sts.out_free;
                if (accept && i_sts.drain_start) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                rd_en   = 1'b1;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                // read data holds until the output register frees up
                if (i_sts.out_free) begin
                    load    = 1'b1;
                    n_state = i_sts.last_idx ? S_RUN : S_READ;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.accept = accept;
    assign o_cmd.rd_en  = rd_en;
    assign o_cmd.load   = load;

    `EFR_ASSERT_NEXT(a_read_then_load, i_clk, i_rst_n, r_state == S_READ, r_state == S_LOAD)
    `EFR_ASSERT_NEXT(a_load_waits, i_clk, i_rst_n, r_state == S_LOAD && !i_sts.out_free, r_state == S_LOAD)
    `EFR_ASSERT_NEXT(a_drain_enters_read, i_clk, i_rst_n, accept && i_sts.drain_start, r_state == S_READ && !accept)

endmodule

// ===== rtl/escaped_frame_receiver_unit.sv =====
// Deframes a byte-stuffed serial stream: 0x7E start, length, command, payload, checksum,
// with 0x7D escaping the next byte. A received byte is taken whenever the output
// register is free and no frame is replaying, so bytes that produce no beat flow at one per
// cycle when not held; an error status or an empty-payload beat is ready on the cycle after
// its byte. A good frame with n payload bytes is replayed from the payload buffer memory
// through its single registered read port (read, then load into the output register), and
// the input stalls through the replay and any output stall. No clearing pass after reset.
module escaped_frame_receiver_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_status,
    output logic [7:0] o_frame_command,
    output logic [7:0] o_payload_byte,
    output logic       o_byte_valid,
    output logic [efr_pkg::BYTE_INDEX_W-1:0] o_byte_index,
    output logic       o_last
);

    efr_pkg::t_dp_cmd cmd;
    efr_pkg::t_dp_sts sts;

    efr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_stall (o_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    efr_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_rx_byte       (i_rx_byte),
        .i_out_stall     (i_stall),
        .o_out_valid     (o_valid),
        .o_status        (o_status),
        .o_frame_command (o_frame_command),
        .o_payload_byte  (o_payload_byte),
        .o_byte_valid    (o_byte_valid),
        .o_byte_index    (o_byte_index),
        .o_last          (o_last)
    );

endmodule
